### hdl/eth_ipv4_l4_header_parser_macros.svh
// Assertion macros used by the parser top level.
`ifndef ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH
`define ETH_IPV4_L4_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ETHL4_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled in reset.
`define ETHL4_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ethl4_pkg.sv
// Types and constants of the Ethernet/IPv4/L4 header parser.
`default_nettype none
package ethl4_pkg;

	localparam int unsigned COUNT_BITS_DEF = 17;

	localparam int unsigned EthLen   = 14;
	localparam int unsigned IpMinLen = 20;
	localparam int unsigned PosEthHi = 12;
	localparam int unsigned PosEthLo = 13;
	localparam int unsigned PosVihl  = 14;
	localparam int unsigned PosTlHi  = 16;
	localparam int unsigned PosTlLo  = 17;
	localparam int unsigned PosFrHi  = 20;
	localparam int unsigned PosFrLo  = 21;
	localparam int unsigned PosProto = 23;
	localparam int unsigned PosSaLo  = 26;
	localparam int unsigned PosSaHi  = 29;
	localparam int unsigned PosDaLo  = 30;
	localparam int unsigned PosDaHi  = 33;
	localparam int unsigned TcpOffByte = 12;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IP_VER4    = 4'd4;
	localparam logic [12:0] FRAG_MASK  = 13'h1FFF;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT_ETH = 3'd1;
	localparam logic [2:0] ST_NOT_IP    = 3'd2;
	localparam logic [2:0] ST_SHORT_IP  = 3'd3;
	localparam logic [2:0] ST_NOT_V4    = 3'd4;
	localparam logic [2:0] ST_LEN_OVER  = 3'd5;
	localparam logic [2:0] ST_BAD_IHL   = 3'd6;

	localparam logic [1:0] L4_NONE = 2'd0;
	localparam logic [1:0] L4_TCP  = 2'd1;
	localparam logic [1:0] L4_UDP  = 2'd2;
	localparam logic [1:0] L4_ICMP = 2'd3;

	// Header fields captured over one frame
	typedef struct packed {
		logic [15:0] ethertype;
		logic [7:0]  ver_ihl;
		logic [15:0] total_len;
		logic [12:0] frag_bits;
		logic [7:0]  proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [31:0] ports;
		logic [3:0]  tcp_off;
	} frame_t;

	// One parse result
	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  l4_kind;
		logic        frag_flag;
		logic [7:0]  proto;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
		logic [15:0] l4_src;
		logic [15:0] l4_dst;
		logic [7:0]  pay_off;
		logic [15:0] pay_len;
	} res_t;

endpackage
`default_nettype wire

### hdl/eth_ipv4_l4_header_parser.sv
// Top level of the Ethernet/IPv4/L4 header parser.
//
// Takes an Ethernet frame one byte per cycle (data_byte, last_byte marks the
// final byte) and gives one result item per frame once its last byte is in:
// a status code (first failing check among short frame, not IPv4 EtherType,
// short IP header, not version 4, total length over the bytes present, IHL
// below 5), the protocol, addresses, fragment flag, and for TCP/UDP/ICMP the
// L4 kind, ports (TCP/UDP only) and payload offset/length. Non-ok status zeroes
// every other field. Throughput is one byte per cycle; after the last byte is
// accepted, the result passes the input register, the capture/snapshot register
// and the result register on its way out. in_stall rises only when a
// last byte sits in the input register while a previous frame's snapshot is
// still held behind a stalled output. The byte counter saturates at
// 2^COUNT_BITS-1 and that value is used as the frame length. Every state
// register clears after each frame, so frames need no gap between them.
`default_nettype none
`include "eth_ipv4_l4_header_parser_macros.svh"
module eth_ipv4_l4_header_parser #(
	parameter int unsigned COUNT_BITS = ethl4_pkg::COUNT_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  status,
	output logic [1:0]  l4_kind,
	output logic        fragment_flag,
	output logic [7:0]  ip_protocol,
	output logic [31:0] source_address,
	output logic [31:0] dest_address,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [7:0]  payload_offset,
	output logic [15:0] payload_length
);

	// input register
	logic                  valid_s1;
	logic                  last_s1;
	logic [7:0]            byte_s1;
	// frame snapshot stage
	logic                  valid_s2;
	ethl4_pkg::frame_t     frame_s2;
	logic [COUNT_BITS-1:0] len_s2;
	// decode and result register
	ethl4_pkg::res_t       res;
	ethl4_pkg::res_t       res_q;
	logic                  out_valid_q;

	logic out_free;
	logic s2_adv;
	logic s2_free;
	logic s1_adv;
	logic in_take;

	// terms for the output checks
	logic res_err;
	logic err_clear;
	logic no_l4;
	logic l4_clear;
	logic has_len;

	assign out_free = !out_valid_q || !out_stall;
	assign s2_adv   = valid_s2 && out_free;
	assign s2_free  = !valid_s2 || out_free;
	// only a last byte needs room in the snapshot stage
	assign s1_adv   = valid_s1 && (!last_s1 || s2_free);
	assign in_stall = valid_s1 && !s1_adv;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ethl4_capture #(
		.COUNT_BITS (COUNT_BITS)
	) u_capture (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (s1_adv),
		.step_last (last_s1),
		.step_byte (byte_s1),
		.frame_s2  (frame_s2),
		.len_s2    (len_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv && last_s1) begin
			valid_s2 <= 1'b1;
		end else if (s2_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	ethl4_result #(
		.COUNT_BITS (COUNT_BITS)
	) u_result (
		.frame (frame_s2),
		.len   (len_s2),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_adv)
			res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign status         = res_q.status;
	assign l4_kind        = res_q.l4_kind;
	assign fragment_flag  = res_q.frag_flag;
	assign ip_protocol    = res_q.proto;
	assign source_address = res_q.src_addr;
	assign dest_address   = res_q.dst_addr;
	assign source_port    = res_q.l4_src;
	assign dest_port      = res_q.l4_dst;
	assign payload_offset = res_q.pay_off;
	assign payload_length = res_q.pay_len;

	assign res_err   = out_valid_q && status != ethl4_pkg::ST_OK;
	assign err_clear = l4_kind == ethl4_pkg::L4_NONE && source_address == 32'd0 &&
		ip_protocol == 8'd0 && payload_length == 16'd0;
	assign no_l4     = out_valid_q && l4_kind == ethl4_pkg::L4_NONE;
	assign l4_clear  = source_port == 16'd0 && dest_port == 16'd0 && payload_offset == 8'd0;
	assign has_len   = out_valid_q && payload_length != 16'd0;

	`ETHL4_ASSERT_NXT(a_last_snapshots, s1_adv && last_s1, valid_s2, "last byte lost its snapshot")
	`ETHL4_ASSERT_IMP(a_err_zeroes, res_err, err_clear, "error result carries fields")
	`ETHL4_ASSERT_IMP(a_no_l4_no_ports, no_l4, l4_clear, "ports without L4 kind")
	`ETHL4_ASSERT_IMP(a_len_has_offset, has_len, payload_offset != 8'd0, "length without offset")

endmodule
`default_nettype wire

### hdl/ethl4_capture.sv
// Byte counter and header field capture, with end-of-frame snapshot.
`default_nettype none
module ethl4_capture #(
	parameter int unsigned COUNT_BITS = ethl4_pkg::COUNT_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         step,
	input  wire                         step_last,
	input  wire  [7:0]                  step_byte,
	output ethl4_pkg::frame_t           frame_s2,
	output logic [COUNT_BITS-1:0]       len_s2
);

	localparam logic [COUNT_BITS-1:0] CntMax = {COUNT_BITS{1'b1}};

	ethl4_pkg::frame_t       frame_q;
	ethl4_pkg::frame_t       frame_nxt;
	logic [COUNT_BITS-1:0]   cnt_q;
	logic [COUNT_BITS-1:0]   cnt_nxt;
	logic [COUNT_BITS-1:0]   pos;
	logic [COUNT_BITS-1:0]   l4_pos;

	assign pos     = cnt_q;
	assign cnt_nxt = (cnt_q == CntMax) ? cnt_q : cnt_q + COUNT_BITS'(1);
	// L4 header start: 14 + 4*IHL (up to 74)
	assign l4_pos  = COUNT_BITS'(7'(ethl4_pkg::EthLen) + {1'b0, frame_q.ver_ihl[3:0], 2'b00});

	always_comb begin
		frame_nxt = frame_q;
		if (pos == COUNT_BITS'(ethl4_pkg::PosEthHi) || pos == COUNT_BITS'(ethl4_pkg::PosEthLo))
			frame_nxt.ethertype = {frame_q.ethertype[7:0], step_byte};
		if (pos == COUNT_BITS'(ethl4_pkg::PosVihl))
			frame_nxt.ver_ihl = step_byte;
		if (pos == COUNT_BITS'(ethl4_pkg::PosTlHi) || pos == COUNT_BITS'(ethl4_pkg::PosTlLo))
			frame_nxt.total_len = {frame_q.total_len[7:0], step_byte};
		if (pos == COUNT_BITS'(ethl4_pkg::PosFrHi) || pos == COUNT_BITS'(ethl4_pkg::PosFrLo))
			frame_nxt.frag_bits = {frame_q.frag_bits[4:0], step_byte} & ethl4_pkg::FRAG_MASK;
		if (pos == COUNT_BITS'(ethl4_pkg::PosProto))
			frame_nxt.proto = step_byte;
		if (pos >= COUNT_BITS'(ethl4_pkg::PosSaLo) && pos <= COUNT_BITS'(ethl4_pkg::PosSaHi))
			frame_nxt.src_addr = {frame_q.src_addr[23:0], step_byte};
		if (pos >= COUNT_BITS'(ethl4_pkg::PosDaLo) && pos <= COUNT_BITS'(ethl4_pkg::PosDaHi))
			frame_nxt.dst_addr = {frame_q.dst_addr[23:0], step_byte};
		if (pos > COUNT_BITS'(ethl4_pkg::PosVihl)) begin
			if (pos >= l4_pos && pos < l4_pos + COUNT_BITS'(4))
				frame_nxt.ports = {frame_q.ports[23:0], step_byte};
			if (pos == l4_pos + COUNT_BITS'(ethl4_pkg::TcpOffByte))
				frame_nxt.tcp_off = step_byte[7:4];
		end
	end

	// Running state; cleared after the last byte of each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			cnt_q   <= '0;
		end else if (step) begin
			if (step_last) begin
				frame_q <= '0;
				cnt_q   <= '0;
			end else begin
				frame_q <= frame_nxt;
				cnt_q   <= cnt_nxt;
			end
		end
	end

	// Snapshot of the finished frame
	always_ff @(posedge clk) begin
		if (step && step_last) begin
			frame_s2 <= frame_nxt;
			len_s2   <= cnt_nxt;
		end
	end

endmodule
`default_nettype wire

### hdl/ethl4_result.sv
// Header checks and L4/payload decode of one captured frame.
`default_nettype none
module ethl4_result #(
	parameter int unsigned COUNT_BITS = ethl4_pkg::COUNT_BITS_DEF
) (
	input  wire ethl4_pkg::frame_t frame,
	input  wire [COUNT_BITS-1:0]   len,
	output ethl4_pkg::res_t        res
);

	logic [COUNT_BITS-1:0] ip_avail;
	logic [5:0]            hl;
	logic [5:0]            th;
	logic [15:0]           rem;
	logic [7:0]            l4_start;
	logic [2:0]            st;

	assign ip_avail = len - COUNT_BITS'(ethl4_pkg::EthLen);
	assign hl       = {frame.ver_ihl[3:0], 2'b00};
	assign th       = {frame.tcp_off, 2'b00};
	assign rem      = frame.total_len - 16'(hl);
	assign l4_start = 8'(ethl4_pkg::EthLen) + 8'(hl);

	// first failing check wins
	always_comb begin
		if (len < COUNT_BITS'(ethl4_pkg::EthLen))
			st = ethl4_pkg::ST_SHORT_ETH;
		else if (frame.ethertype != ethl4_pkg::ETYPE_IPV4)
			st = ethl4_pkg::ST_NOT_IP;
		else if (ip_avail < COUNT_BITS'(ethl4_pkg::IpMinLen))
			st = ethl4_pkg::ST_SHORT_IP;
		else if (frame.ver_ihl[7:4] != ethl4_pkg::IP_VER4)
			st = ethl4_pkg::ST_NOT_V4;
		else if (COUNT_BITS'(frame.total_len) > ip_avail)
			st = ethl4_pkg::ST_LEN_OVER;
		else if (hl < 6'(ethl4_pkg::IpMinLen))
			st = ethl4_pkg::ST_BAD_IHL;
		else
			st = ethl4_pkg::ST_OK;
	end

	always_comb begin
		res        = '0;
		res.status = st;
		if (st == ethl4_pkg::ST_OK) begin
			res.proto     = frame.proto;
			res.src_addr  = frame.src_addr;
			res.dst_addr  = frame.dst_addr;
			res.frag_flag = |frame.frag_bits;
			// total length below header length leaves no L4 header
			if (frame.total_len >= 16'(hl)) begin
				if (frame.proto == ethl4_pkg::PROTO_TCP && rem >= 16'd20) begin
					res.l4_kind = ethl4_pkg::L4_TCP;
					res.l4_src  = frame.ports[31:16];
					res.l4_dst  = frame.ports[15:0];
					if (th >= 6'd20 && rem > 16'(th)) begin
						res.pay_off = l4_start + 8'(th);
						res.pay_len = rem - 16'(th);
					end
				end else if (frame.proto == ethl4_pkg::PROTO_UDP && rem >= 16'd8) begin
					res.l4_kind = ethl4_pkg::L4_UDP;
					res.l4_src  = frame.ports[31:16];
					res.l4_dst  = frame.ports[15:0];
					if (rem > 16'd8) begin
						res.pay_off = l4_start + 8'd8;
						res.pay_len = rem - 16'd8;
					end
				end else if (frame.proto == ethl4_pkg::PROTO_ICMP && rem >= 16'd8) begin
					// ICMP gives the offset even for an empty payload
					res.l4_kind = ethl4_pkg::L4_ICMP;
					res.pay_off = l4_start + 8'd8;
					res.pay_len = rem - 16'd8;
				end
			end
		end
	end

endmodule
`default_nettype wire
